[rtl/core/ect_pkg.sv]
// Shared types and constants of the ear clipping triangulator.
// No dependencies; ect_if, ect_back, top and benches import it.
`timescale 1ns / 1ps
package ect_pkg;
  localparam int TOL_W    = 22;
  localparam int CORNER_W = 6;

  typedef logic [TOL_W-1:0] tol_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic                success;
    logic                final_triangle;
  } result_t;
endpackage

[rtl/core/ect_if.sv]
// Valid/ready channel interfaces for vertex words and triangle result words.
// Depends on ect_pkg.
`timescale 1ns / 1ps
interface ect_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         final_vertex;
  modport source(output valid, vertex_x, vertex_y, final_vertex, input ready);
  modport sink(input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

interface ect_out_if;
  import ect_pkg::*;
  logic                valid;
  logic                ready;
  logic [CORNER_W-1:0] corner_a;
  logic [CORNER_W-1:0] corner_b;
  logic [CORNER_W-1:0] corner_c;
  logic                success;
  logic                final_triangle;
  modport source(output valid, corner_a, corner_b, corner_c, success, final_triangle,
                 input ready);
  modport sink(input valid, corner_a, corner_b, corner_c, success, final_triangle,
               output ready);
endinterface

[rtl/core/ect_front.sv]
// Front end: accepts vertex words, writes them to the vertex store and queues
// one job per polygon. Depends on nothing but its ports.
`timescale 1ns / 1ps
module ect_front #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24,
  parameter int IW           = 6,
  parameter int CW           = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_final,
  output logic                         in_ready,
  output logic                         wr_en,
  output logic [IW-1:0]                wr_addr,
  output logic signed [COORD_BITS-1:0] wr_x,
  output logic signed [COORD_BITS-1:0] wr_y,
  output logic                         job_push,
  output logic [CW-1:0]                job_n,
  output logic                         job_ovf,
  input  logic                         job_full,
  input  logic                         done
);
  logic [CW-1:0] cnt_r;
  logic          ovf_r;
  logic          hold_r;
  logic          acc;

  assign in_ready = !hold_r && !job_full;
  assign acc      = in_valid && in_ready;
  assign wr_en    = acc && (cnt_r < CW'(MAX_VERTICES));
  assign wr_addr  = cnt_r[IW-1:0];
  assign wr_x     = in_x;
  assign wr_y     = in_y;
  assign job_n    = wr_en ? cnt_r + CW'(1) : cnt_r;
  assign job_ovf  = ovf_r || (acc && !wr_en);
  assign job_push = acc && in_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      if (done) begin
        hold_r <= 1'b0;
      end
      if (acc) begin
        if (in_final) begin
          cnt_r  <= '0;
          ovf_r  <= 1'b0;
          hold_r <= 1'b1;
        end else begin
          cnt_r <= job_n;
          ovf_r <= job_ovf;
        end
      end
    end
  end
endmodule

[rtl/core/ect_fifo.sv]
// Two-entry job queue between the front end and the triangulation engine.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module ect_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);
  logic [W-1:0] mem_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end
endmodule

[rtl/core/ect_cross.sv]
// Multi-cycle cross product unit: (b-a) x (c-a) with one shared multiplier.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module ect_cross #(
  parameter int OW = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [OW-1:0]   ax,
  input  logic signed [OW-1:0]   ay,
  input  logic signed [OW-1:0]   bx,
  input  logic signed [OW-1:0]   by,
  input  logic signed [OW-1:0]   cx,
  input  logic signed [OW-1:0]   cy,
  output logic                   done,
  output logic signed [2*OW+2:0] res
);
  typedef enum logic [1:0] {CX_IDLE, CX_MUL1, CX_MUL2, CX_SUB} cx_state_t;

  cx_state_t                 state_r;
  logic signed [OW:0]        dbx_r, dby_r, dcx_r, dcy_r;
  logic signed [2*OW+1:0]    p1_r, p2_r;
  logic signed [2*OW+2:0]    res_r;
  logic                      done_r;
  logic signed [OW:0]        ma, mb;
  logic signed [2*OW+1:0]    prod;

  assign ma   = (state_r == CX_MUL1) ? dbx_r : dby_r;
  assign mb   = (state_r == CX_MUL1) ? dcy_r : dcx_r;
  assign prod = ma * mb;
  assign done = done_r;
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CX_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        CX_IDLE: begin
          if (start) begin
            dbx_r   <= (OW+1)'(bx) - (OW+1)'(ax);
            dby_r   <= (OW+1)'(by) - (OW+1)'(ay);
            dcx_r   <= (OW+1)'(cx) - (OW+1)'(ax);
            dcy_r   <= (OW+1)'(cy) - (OW+1)'(ay);
            state_r <= CX_MUL1;
          end
        end
        CX_MUL1: begin
          p1_r    <= prod;
          state_r <= CX_MUL2;
        end
        CX_MUL2: begin
          p2_r    <= prod;
          state_r <= CX_SUB;
        end
        CX_SUB: begin
          res_r   <= (2*OW+3)'(p1_r) - (2*OW+3)'(p2_r);
          done_r  <= 1'b1;
          state_r <= CX_IDLE;
        end
        default: state_r <= CX_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/ect_back.sv]
// Triangulation engine: vertex store, active vertex mask, ear search sequencer,
// triangle store and result register. Depends on ect_pkg and ect_cross.
`timescale 1ns / 1ps
module ect_back #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24,
  parameter int IW           = 6,
  parameter int CW           = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ect_pkg::tol_t                tol,
  input  logic                         wr_en,
  input  logic [IW-1:0]                wr_addr,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  logic                         job_valid,
  input  logic [CW-1:0]                job_n,
  input  logic                         job_ovf,
  output logic                         job_pop,
  output logic                         done,
  output logic                         res_valid,
  output ect_pkg::result_t             res,
  input  logic                         res_ready
);
  import ect_pkg::*;

  localparam int OW = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W + 1;
  localparam int RW = 2 * OW + 3;
  localparam int AW = RW + IW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_AREA_RD, S_AREA_LDI, S_AREA_LDJ, S_AREA_W, S_TOL_W,
    S_PASS_SCAN, S_LD_PV, S_LD_CU, S_LD_CU2, S_SEEK, S_LD_NX, S_CONV_W,
    S_Q_CHK, S_Q_LD, S_C1_W, S_C2_W, S_C3_W, S_NEXT, S_EAR,
    S_FIN_SCAN, S_FIN_WR, S_E_RD, S_E_OUT, S_FAIL
  } state_t;

  logic signed [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] vy_mem [MAX_VERTICES];
  logic [3*IW-1:0]              tri_mem [MAX_VERTICES-2];

  state_t                  state_r;
  logic signed [COORD_BITS-1:0] rx_r, ry_r;
  logic [3*IW-1:0]         trd_r;
  logic [IW-1:0]           rd_addr;
  logic [MAX_VERTICES-1:0] mask_r;
  logic [CW-1:0]           n_r, m_r, i_r, sp_r, q_r, tested_r, t_r, e_r;
  logic [IW-1:0]           pv_r, cu_r, nx_r, first_r, last_r, f0_r, f1_r, f2_r;
  logic [1:0]              fcnt_r;
  logic                    seen_r, neg_r, pos_r, ccw_r;
  logic signed [OW-1:0]    pvx_r, pvy_r, cux_r, cuy_r, nxx_r, nxy_r, qx_r, qy_r;
  logic signed [OW-1:0]    ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic                    cx_start_r;
  logic                    cx_done;
  logic signed [RW-1:0]    cx_res;
  logic signed [AW-1:0]    acc_r;
  logic [AW-1:0]           mag;
  logic [AW-1:0]           lim;
  logic signed [RW-1:0]    eps;
  logic                    gt_eps, lt_neps, neg_all, pos_all;
  logic                    out_v_r, done_r;
  result_t                 out_r;
  logic [CW-1:0]           i_nxt, j_nxt, sp_nxt, q_nxt;
  logic signed [OW-1:0]    rxe, rye, tole;

  function automatic logic [CW-1:0] inc_wrap(input logic [CW-1:0] v,
                                             input logic [CW-1:0] lim_v);
    logic [CW-1:0] s;
    s = v + CW'(1);
    return (s == lim_v) ? '0 : s;
  endfunction

  ect_cross #(.OW(OW)) u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cx_start_r),
    .ax    (ax_r),
    .ay    (ay_r),
    .bx    (bx_r),
    .by    (by_r),
    .cx    (cx_r),
    .cy    (cy_r),
    .done  (cx_done),
    .res   (cx_res)
  );

  assign rxe     = OW'(rx_r);
  assign rye     = OW'(ry_r);
  assign tole    = OW'($signed({1'b0, tol}));
  assign eps     = RW'($signed({1'b0, tol}));
  assign gt_eps  = cx_res > eps;
  assign lt_neps = cx_res < -eps;
  assign neg_all = neg_r || lt_neps;
  assign pos_all = pos_r || gt_eps;
  assign mag     = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign lim     = AW'($unsigned(cx_res)) << 1;
  assign i_nxt   = i_r + CW'(1);
  assign j_nxt   = inc_wrap(i_r, n_r);
  assign sp_nxt  = sp_r + CW'(1);
  assign q_nxt   = q_r + CW'(1);
  assign job_pop = (state_r == S_IDLE) && job_valid;
  assign done    = done_r;
  assign res_valid = out_v_r;
  assign res     = out_r;

  always_comb begin
    unique case (state_r)
      S_AREA_RD:  rd_addr = i_r[IW-1:0];
      S_AREA_LDI: rd_addr = j_nxt[IW-1:0];
      S_LD_PV:    rd_addr = last_r;
      S_LD_CU:    rd_addr = cu_r;
      S_SEEK:     rd_addr = sp_r[IW-1:0];
      S_Q_CHK:    rd_addr = q_r[IW-1:0];
      default:    rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vx_mem[wr_addr] <= wr_x;
      vy_mem[wr_addr] <= wr_y;
    end
    rx_r <= vx_mem[rd_addr];
    ry_r <= vy_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EAR) begin
      tri_mem[t_r[IW-1:0]] <= {pv_r, cu_r, nx_r};
    end else if (state_r == S_FIN_WR) begin
      tri_mem[t_r[IW-1:0]] <= {f0_r, f1_r, f2_r};
    end
    trd_r <= tri_mem[e_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_v_r    <= 1'b0;
      done_r     <= 1'b0;
      cx_start_r <= 1'b0;
      ccw_r      <= 1'b0;
    end else begin
      cx_start_r <= 1'b0;
      done_r     <= 1'b0;
      if (out_v_r && res_ready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            n_r   <= job_n;
            m_r   <= job_n;
            i_r   <= '0;
            t_r   <= '0;
            acc_r <= '0;
            for (int b = 0; b < MAX_VERTICES; b++) begin
              mask_r[b] <= (CW'(b) < job_n);
            end
            if (job_ovf || (job_n < CW'(3))) begin
              state_r <= S_FAIL;
            end else begin
              state_r <= S_AREA_RD;
            end
          end
        end
        S_AREA_RD: state_r <= S_AREA_LDI;
        S_AREA_LDI: begin
          cux_r   <= rxe;
          cuy_r   <= rye;
          state_r <= S_AREA_LDJ;
        end
        S_AREA_LDJ: begin
          ax_r       <= '0;
          ay_r       <= '0;
          bx_r       <= cux_r;
          by_r       <= cuy_r;
          cx_r       <= rxe;
          cy_r       <= rye;
          cx_start_r <= 1'b1;
          state_r    <= S_AREA_W;
        end
        S_AREA_W: begin
          if (cx_done) begin
            acc_r <= acc_r + AW'(cx_res);
            i_r   <= i_nxt;
            if (i_nxt == n_r) begin
              ax_r       <= '0;
              ay_r       <= '0;
              bx_r       <= tole;
              by_r       <= '0;
              cx_r       <= '0;
              cy_r       <= tole;
              cx_start_r <= 1'b1;
              state_r    <= S_TOL_W;
            end else begin
              state_r <= S_AREA_RD;
            end
          end
        end
        S_TOL_W: begin
          if (cx_done) begin
            if (mag <= lim) begin
              state_r <= S_FAIL;
            end else begin
              ccw_r  <= !acc_r[AW-1] && (acc_r != '0);
              sp_r   <= '0;
              seen_r <= 1'b0;
              fcnt_r <= '0;
              state_r <= (m_r == CW'(3)) ? S_FIN_SCAN : S_PASS_SCAN;
            end
          end
        end
        S_PASS_SCAN: begin
          if (mask_r[sp_r[IW-1:0]]) begin
            if (!seen_r) begin
              first_r <= sp_r[IW-1:0];
            end
            seen_r <= 1'b1;
            last_r <= sp_r[IW-1:0];
          end
          sp_r <= sp_nxt;
          if (sp_nxt == n_r) begin
            tested_r <= '0;
            state_r  <= S_LD_PV;
          end
        end
        S_LD_PV: begin
          pv_r    <= last_r;
          cu_r    <= first_r;
          state_r <= S_LD_CU;
        end
        S_LD_CU: begin
          pvx_r   <= rxe;
          pvy_r   <= rye;
          state_r <= S_LD_CU2;
        end
        S_LD_CU2: begin
          cux_r   <= rxe;
          cuy_r   <= rye;
          sp_r    <= inc_wrap(CW'(cu_r), n_r);
          state_r <= S_SEEK;
        end
        S_SEEK: begin
          if (mask_r[sp_r[IW-1:0]]) begin
            nx_r    <= sp_r[IW-1:0];
            state_r <= S_LD_NX;
          end else begin
            sp_r <= inc_wrap(sp_r, n_r);
          end
        end
        S_LD_NX: begin
          nxx_r      <= rxe;
          nxy_r      <= rye;
          ax_r       <= pvx_r;
          ay_r       <= pvy_r;
          bx_r       <= cux_r;
          by_r       <= cuy_r;
          cx_r       <= rxe;
          cy_r       <= rye;
          cx_start_r <= 1'b1;
          state_r    <= S_CONV_W;
        end
        S_CONV_W: begin
          if (cx_done) begin
            q_r <= '0;
            if (ccw_r ? gt_eps : lt_neps) begin
              state_r <= S_Q_CHK;
            end else begin
              state_r <= S_NEXT;
            end
          end
        end
        S_Q_CHK: begin
          if (q_r == n_r) begin
            state_r <= S_EAR;
          end else if (mask_r[q_r[IW-1:0]] && (q_r[IW-1:0] != pv_r) &&
                       (q_r[IW-1:0] != cu_r) && (q_r[IW-1:0] != nx_r)) begin
            state_r <= S_Q_LD;
          end else begin
            q_r <= q_nxt;
          end
        end
        S_Q_LD: begin
          qx_r       <= rxe;
          qy_r       <= rye;
          ax_r       <= pvx_r;
          ay_r       <= pvy_r;
          bx_r       <= cux_r;
          by_r       <= cuy_r;
          cx_r       <= rxe;
          cy_r       <= rye;
          cx_start_r <= 1'b1;
          state_r    <= S_C1_W;
        end
        S_C1_W: begin
          if (cx_done) begin
            neg_r      <= lt_neps;
            pos_r      <= gt_eps;
            ax_r       <= cux_r;
            ay_r       <= cuy_r;
            bx_r       <= nxx_r;
            by_r       <= nxy_r;
            cx_r       <= qx_r;
            cy_r       <= qy_r;
            cx_start_r <= 1'b1;
            state_r    <= S_C2_W;
          end
        end
        S_C2_W: begin
          if (cx_done) begin
            neg_r      <= neg_all;
            pos_r      <= pos_all;
            ax_r       <= nxx_r;
            ay_r       <= nxy_r;
            bx_r       <= pvx_r;
            by_r       <= pvy_r;
            cx_r       <= qx_r;
            cy_r       <= qy_r;
            cx_start_r <= 1'b1;
            state_r    <= S_C3_W;
          end
        end
        S_C3_W: begin
          if (cx_done) begin
            if (!(neg_all && pos_all)) begin
              state_r <= S_NEXT;
            end else begin
              q_r     <= q_nxt;
              state_r <= S_Q_CHK;
            end
          end
        end
        S_NEXT: begin
          if (tested_r + CW'(1) == m_r) begin
            state_r <= S_FAIL;
          end else begin
            tested_r <= tested_r + CW'(1);
            pv_r     <= cu_r;
            pvx_r    <= cux_r;
            pvy_r    <= cuy_r;
            cu_r     <= nx_r;
            cux_r    <= nxx_r;
            cuy_r    <= nxy_r;
            sp_r     <= inc_wrap(CW'(nx_r), n_r);
            state_r  <= S_SEEK;
          end
        end
        S_EAR: begin
          t_r          <= t_r + CW'(1);
          mask_r[cu_r] <= 1'b0;
          m_r          <= m_r - CW'(1);
          sp_r         <= '0;
          seen_r       <= 1'b0;
          fcnt_r       <= '0;
          state_r      <= (m_r - CW'(1) == CW'(3)) ? S_FIN_SCAN : S_PASS_SCAN;
        end
        S_FIN_SCAN: begin
          if (mask_r[sp_r[IW-1:0]]) begin
            case (fcnt_r)
              2'd0:    f0_r <= sp_r[IW-1:0];
              2'd1:    f1_r <= sp_r[IW-1:0];
              default: f2_r <= sp_r[IW-1:0];
            endcase
            fcnt_r <= fcnt_r + 2'd1;
          end
          sp_r <= sp_nxt;
          if (sp_nxt == n_r) begin
            state_r <= S_FIN_WR;
          end
        end
        S_FIN_WR: begin
          t_r     <= t_r + CW'(1);
          e_r     <= '0;
          state_r <= S_E_RD;
        end
        S_E_RD: state_r <= S_E_OUT;
        S_E_OUT: begin
          if (!out_v_r || res_ready) begin
            out_v_r              <= 1'b1;
            out_r.corner_a       <= CORNER_W'(trd_r[3*IW-1:2*IW]);
            out_r.corner_b       <= CORNER_W'(trd_r[2*IW-1:IW]);
            out_r.corner_c       <= CORNER_W'(trd_r[IW-1:0]);
            out_r.success        <= 1'b1;
            out_r.final_triangle <= (e_r + CW'(1) == t_r);
            e_r                  <= e_r + CW'(1);
            if (e_r + CW'(1) == t_r) begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_E_RD;
            end
          end
        end
        S_FAIL: begin
          if (!out_v_r || res_ready) begin
            out_v_r              <= 1'b1;
            out_r.corner_a       <= '0;
            out_r.corner_b       <= '0;
            out_r.corner_c       <= '0;
            out_r.success        <= 1'b0;
            out_r.final_triangle <= 1'b1;
            done_r               <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/ear_clipping_triangulator.sv]
// Ear clipping triangulator top level: front end, job queue, engine, APB port.
// Depends on ect_pkg, ect_if, ect_front, ect_fifo, ect_cross and ect_back.
// Vertices load at one word per cycle while ready is high; a polygon of n
// vertices then needs n cross products for the signed area, up to n ear
// passes of scanning plus up to n candidates each, and every candidate
// needs its corner test plus up to n containment checks. All products run
// on the single shared cross product unit, which runs two multiplications
// and one subtraction per product. The input holds ready low from the
// final vertex until all results of that polygon are queued.
`timescale 1ns / 1ps
module ear_clipping_triangulator #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  ect_in_if.sink       in_ch,
  ect_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ect_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  tol_t                         tol_r;
  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  logic signed [COORD_BITS-1:0] wr_x, wr_y;
  logic                         job_push, job_pop, job_empty, job_full;
  logic [CW-1:0]                job_n;
  logic                         job_ovf;
  logic [CW:0]                  job_in, job_out;
  logic                         done;
  result_t                      res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(tol_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  ect_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .IW           (IW),
    .CW           (CW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_x     (in_ch.vertex_x),
    .in_y     (in_ch.vertex_y),
    .in_final (in_ch.final_vertex),
    .in_ready (in_ch.ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_x     (wr_x),
    .wr_y     (wr_y),
    .job_push (job_push),
    .job_n    (job_n),
    .job_ovf  (job_ovf),
    .job_full (job_full),
    .done     (done)
  );

  assign job_in = {job_ovf, job_n};

  ect_fifo #(.W(CW + 1)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty),
    .full  (job_full)
  );

  ect_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .IW           (IW),
    .CW           (CW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tol       (tol_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_x      (wr_x),
    .wr_y      (wr_y),
    .job_valid (!job_empty),
    .job_n     (job_out[CW-1:0]),
    .job_ovf   (job_out[CW]),
    .job_pop   (job_pop),
    .done      (done),
    .res_valid (out_ch.valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.corner_a       = res.corner_a;
  assign out_ch.corner_b       = res.corner_b;
  assign out_ch.corner_c       = res.corner_c;
  assign out_ch.success        = res.success;
  assign out_ch.final_triangle = res.final_triangle;
endmodule

[sim/tb_checker.sv]
// Checker for the ear clipping triangulator: watches the vertex, result and APB ports,
// predicts every triangle word and compares it. Depends on ect_pkg and ect_if.
`timescale 1ns / 1ps
module tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  ect_in_if           in_ch,
  ect_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          pending,
  output int          failures
);
  import ect_pkg::*;

  localparam int MAXV = 64;
  localparam logic [2:0] ADDR_TOLERANCE = 3'd0;

  longint     vert_x [MAXV];
  longint     vert_y [MAXV];
  logic [5:0] ring [MAXV];
  logic [5:0] tri_a [MAXV];
  logic [5:0] tri_b [MAXV];
  logic [5:0] tri_c [MAXV];
  int         stored_count = 0;
  bit         dropped = 0;
  bit         ccw = 0;
  longint     tol = 1;
  result_t    triangles_due [$];

  assign pending = triangles_due.size();

  function automatic longint cross3(int a, int b, int c);
    longint bx, by, cx, cy;
    bx = vert_x[b] - vert_x[a];
    by = vert_y[b] - vert_y[a];
    cx = vert_x[c] - vert_x[a];
    cy = vert_y[c] - vert_y[a];
    return bx * cy - by * cx;
  endfunction

  function automatic bit in_triangle(int p, int a, int b, int c);
    longint c1, c2, c3;
    bit neg, pos;
    c1 = cross3(a, b, p);
    c2 = cross3(b, c, p);
    c3 = cross3(c, a, p);
    neg = c1 < -tol || c2 < -tol || c3 < -tol;
    pos = c1 > tol || c2 > tol || c3 > tol;
    return !(neg && pos);
  endfunction

  function automatic bit convex_corner(int a, int b, int c);
    longint cr;
    cr = cross3(a, b, c);
    return ccw ? (cr > tol) : (cr < -tol);
  endfunction

  // Returns the triangle count, zero when the polygon fails.
  function automatic int clip_ears(int n);
    int t, m, i, j, k, pv, cu, nx, q;
    longint area2, mag, lim;
    bit clipped, hit;
    t = 0;
    area2 = 0;
    if (dropped || n < 3) return 0;
    for (i = 0; i < n; i++) begin
      j = (i + 1) % n;
      area2 += vert_x[i] * vert_y[j] - vert_y[i] * vert_x[j];
    end
    mag = area2 < 0 ? -area2 : area2;
    lim = 2 * tol * tol;
    if (mag <= lim) return 0;
    ccw = area2 > 0;
    for (i = 0; i < n; i++) ring[i] = i[5:0];
    m = n;
    while (m > 3) begin
      clipped = 0;
      for (i = 0; i < m && !clipped; i++) begin
        pv = ring[(i + m - 1) % m];
        cu = ring[i];
        nx = ring[(i + 1) % m];
        hit = 0;
        if (!convex_corner(pv, cu, nx)) continue;
        for (k = 0; k < m && !hit; k++) begin
          q = ring[k];
          if (q == pv || q == cu || q == nx) continue;
          hit = in_triangle(q, pv, cu, nx);
        end
        if (hit) continue;
        tri_a[t] = pv[5:0];
        tri_b[t] = cu[5:0];
        tri_c[t] = nx[5:0];
        t++;
        for (j = i; j < m - 1; j++) ring[j] = ring[j + 1];
        m--;
        clipped = 1;
      end
      if (!clipped) return 0;
    end
    tri_a[t] = ring[0];
    tri_b[t] = ring[1];
    tri_c[t] = ring[2];
    return t + 1;
  endfunction

  function automatic void take_vertex(logic signed [23:0] x, logic signed [23:0] y,
                                      logic fin);
    int t;
    result_t r;
    if (stored_count < MAXV) begin
      vert_x[stored_count] = longint'(x);
      vert_y[stored_count] = longint'(y);
      stored_count++;
    end else begin
      dropped = 1;
    end
    if (!fin) return;
    t = clip_ears(stored_count);
    stored_count = 0;
    dropped = 0;
    if (t == 0) begin
      r = '0;
      r.final_triangle = 1'b1;
      triangles_due = {triangles_due, r};
    end else begin
      for (int k = 0; k < t; k++) begin
        r.corner_a = tri_a[k];
        r.corner_b = tri_b[k];
        r.corner_c = tri_c[k];
        r.success = 1'b1;
        r.final_triangle = (k + 1 == t);
        triangles_due = {triangles_due, r};
      end
    end
  endfunction

  initial failures = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr == ADDR_TOLERANCE)
        tol = longint'(pwdata[TOL_W-1:0]);
      if (in_ch.valid && in_ch.ready)
        take_vertex(in_ch.vertex_x, in_ch.vertex_y, in_ch.final_vertex);
      if (out_ch.valid && out_ch.ready) begin
        if (triangles_due.size() == 0) begin
          $error("unexpected result word a=%0d b=%0d c=%0d success=%0b",
                 out_ch.corner_a, out_ch.corner_b, out_ch.corner_c, out_ch.success);
          failures++;
        end else begin
          want = triangles_due.pop_front();
          if (out_ch.corner_a !== want.corner_a) begin
            $error("corner_a expected %0d actual %0d", want.corner_a, out_ch.corner_a);
            failures++;
          end
          if (out_ch.corner_b !== want.corner_b) begin
            $error("corner_b expected %0d actual %0d", want.corner_b, out_ch.corner_b);
            failures++;
          end
          if (out_ch.corner_c !== want.corner_c) begin
            $error("corner_c expected %0d actual %0d", want.corner_c, out_ch.corner_c);
            failures++;
          end
          if (out_ch.success !== want.success) begin
            $error("success expected %0b actual %0b", want.success, out_ch.success);
            failures++;
          end
          if (out_ch.final_triangle !== want.final_triangle) begin
            $error("final_triangle expected %0b actual %0b", want.final_triangle,
                   out_ch.final_triangle);
            failures++;
          end
        end
      end
    end
  end
endmodule

[sim/tb_top.sv]
// Testbench top for the ear clipping triangulator: clock, reset, polygon stimulus,
// APB tolerance writes, verdict. Depends on ect_pkg, ect_if, tb_checker, the DUT.
`timescale 1ns / 1ps
module tb_top;
  import ect_pkg::*;

  localparam logic [2:0] ADDR_TOLERANCE = 3'd0;
  localparam real TWO_PI = 6.283185307179586;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          failures;
  int          words_sent = 0;
  bit          quiet = 0;
  int          out_stall = 0;

  ect_in_if #(.COORD_BITS(24)) in_ch();
  ect_out_if out_ch();

  ear_clipping_triangulator u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .pending(pending), .failures(failures)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.vertex_x = '0;
    in_ch.vertex_y = '0;
    in_ch.final_vertex = 0;
    out_ch.ready = 0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_ch.ready <= 0;
      out_stall <= out_stall - 1;
    end else begin
      out_ch.ready <= 1;
      out_stall <= pick_gap();
    end
  end

  // Valid stays high after the handshake; the next call either drives a new
  // word at the same edge or drops valid for a gap.
  task automatic send_vertex(longint x, longint y, bit fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.vertex_x <= x[23:0];
    in_ch.vertex_y <= y[23:0];
    in_ch.final_vertex <= fin;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [31:0] v);
    wait_idle();
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_TOLERANCE;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  // Star-shaped polygon around a random center; equal radii give a convex one.
  task automatic send_star(int n, int rbits, bit convex, bit reverse);
    longint rmax, cx, cy, lim, x, y;
    real r, ang;
    int idx;
    rmax = longint'(1) << rbits;
    lim = 8388607 - rmax;
    cx = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    cy = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    for (int i = 0; i < n; i++) begin
      idx = reverse ? n - 1 - i : i;
      ang = TWO_PI * (real'(idx) + 0.4 * ($urandom_range(0, 1000) / 1000.0)) / n;
      r = convex ? real'(rmax) : real'($urandom_range(32'(rmax / 4), 32'(rmax)));
      x = cx + longint'(r * $cos(ang));
      y = cy + longint'(r * $sin(ang));
      send_vertex(x, y, i == n - 1);
    end
  endtask

  task automatic send_noise(int n, bit dup);
    longint x, y;
    for (int i = 0; i < n; i++) begin
      if (!(dup && i > 0 && $urandom_range(0, 3) == 0)) begin
        x = longint'(signed'(24'($urandom)));
        y = longint'(signed'(24'($urandom)));
      end
      send_vertex(x, y, i == n - 1);
    end
  endtask

  task automatic random_phase(int count);
    int target, n, sel;
    target = words_sent + count;
    while (words_sent < target) begin
      quiet = ($urandom_range(0, 5) == 0);
      sel = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 10) : $urandom_range(11, 20);
      if (sel < 45) send_star(n, $urandom_range(3, 22), 0, $urandom_range(0, 1));
      else if (sel < 75) send_star(n, $urandom_range(3, 22), 1, $urandom_range(0, 1));
      else if (sel < 88) send_noise($urandom_range(1, 8), $urandom_range(0, 1));
      else send_star($urandom_range(1, 2), $urandom_range(3, 22), 1, 0);
    end
    quiet = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_vertex(0, 0, 0); send_vertex(100, 0, 0); send_vertex(0, 100, 1);
    send_vertex(0, 0, 0); send_vertex(0, 100, 0); send_vertex(100, 0, 1);
    send_vertex(0, 0, 0); send_vertex(40, 20, 0); send_vertex(80, 0, 0);
    send_vertex(40, 80, 1);
    send_vertex(5, 5, 0); send_vertex(9, 9, 1);
    send_vertex(7, 7, 1);
    send_vertex(0, 0, 0); send_vertex(10, 10, 0); send_vertex(20, 20, 1);
    send_vertex(0, 0, 0); send_vertex(50, 0, 0); send_vertex(50, 50, 0);
    send_vertex(50, 0, 1);
    send_vertex(-8388608, -8388608, 0); send_vertex(8388607, -8388608, 0);
    send_vertex(8388607, 8388607, 1);

    random_phase(35);
    write_tolerance(32'd0);
    random_phase(25);
    write_tolerance(32'd4194303);
    send_vertex(-8388608, -8388608, 0); send_vertex(8388607, -8388608, 0);
    send_vertex(8388607, 8388607, 0); send_vertex(-8388608, 8388607, 1);
    random_phase(15);
    write_tolerance(32'($urandom_range(2, 4000)));
    random_phase(20);
    send_star(64, 21, 1, 0);
    send_noise(65, 0);
    write_tolerance(32'd1);
    send_star(12, 20, 1, 1);
    random_phase(10);

    wait_idle();
    repeat (200) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
